### hdl/ps2h_pkg.sv
// Shared types and constants for the PS/2 host byte transfer block.
package ps2h_pkg;

  localparam int unsigned TICK_W = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_SETUP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_RELEASE = 2'd3;

  localparam logic [TICK_W-1:0] INHIBIT_RESET    = 10'd255;
  localparam logic [TICK_W-1:0] REQ_SETUP_RESET  = 10'd10;
  localparam logic [TICK_W-1:0] STOP_HOLD_RESET  = 10'd50;
  localparam logic [TICK_W-1:0] RX_RELEASE_RESET = 10'd50;
  localparam logic [TICK_W-1:0] READ_GAP_TICKS   = 10'd5;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_W_REL, PH_W_INH, PH_W_REQ, PH_W_DEV,
    PH_W_BIT_HI, PH_W_BIT_LO, PH_W_PAR_HI, PH_W_PAR_LO,
    PH_W_STOP, PH_W_ACK, PH_W_END,
    PH_R_REL, PH_R_WAIT_LO, PH_R_GAP, PH_R_START_HI,
    PH_R_BIT_LO, PH_R_BIT_HI, PH_R_PAR_LO, PH_R_PAR_HI,
    PH_R_STP_LO, PH_R_STP_HI
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] inhibit_ticks;
    logic [TICK_W-1:0] request_setup_ticks;
    logic [TICK_W-1:0] stop_hold_ticks;
    logic [TICK_W-1:0] rx_release_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       clock_level;
    logic       data_level;
  } item_t;

  typedef struct packed {
    logic       clock_drive_low;
    logic       data_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } result_t;

endpackage

### hdl/ps2h_if.sv
// Handshake channel interfaces for tick input, result output and configuration.
interface ps2h_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] tx_byte;
  logic       clock_level;
  logic       data_level;

  modport source (output valid, operation, tx_byte, clock_level, data_level, input ready);
  modport sink (input valid, operation, tx_byte, clock_level, data_level, output ready);
endinterface

interface ps2h_rsp_if;
  logic       valid;
  logic       ready;
  logic       clock_drive_low;
  logic       data_drive_low;
  logic       busy_res;
  logic       done_res;
  logic       rx_valid;
  logic [7:0] rx_byte;

  modport source (output valid, clock_drive_low, data_drive_low, busy_res, done_res,
                  rx_valid, rx_byte, input ready);
  modport sink (input valid, clock_drive_low, data_drive_low, busy_res, done_res,
                rx_valid, rx_byte, output ready);
endinterface

interface ps2h_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ps2h_pkg::CFG_IDX_W-1:0]   index;
  logic [ps2h_pkg::TICK_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/ps2h_cfg_regs.sv
// Configuration register file holding the four wait lengths.
module ps2h_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ps2h_cfg_if.sink      cfg,
  output ps2h_pkg::cfg_t cfg_q
);
  import ps2h_pkg::*;

  cfg_t regs;

  assign cfg.ready = 1'b1;
  assign cfg_q     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.inhibit_ticks       <= INHIBIT_RESET;
      regs.request_setup_ticks <= REQ_SETUP_RESET;
      regs.stop_hold_ticks     <= STOP_HOLD_RESET;
      regs.rx_release_ticks    <= RX_RELEASE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_INHIBIT:    regs.inhibit_ticks       <= cfg.data;
        CFG_REQ_SETUP:  regs.request_setup_ticks <= cfg.data;
        CFG_STOP_HOLD:  regs.stop_hold_ticks     <= cfg.data;
        CFG_RX_RELEASE: regs.rx_release_ticks    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/ps2h_engine.sv
// Phase machine: state registers and the next-state logic for one tick.
module ps2h_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ps2h_pkg::cfg_t    cfg_q,
  input  ps2h_pkg::item_t   item,
  output ps2h_pkg::result_t res
);
  import ps2h_pkg::*;

  phase_t            phase, phase_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic              parity_acc, parity_acc_next;
  logic [TICK_W-1:0] wait_timer, wait_timer_next;
  logic              clock_hold, clock_hold_next;
  logic              data_hold, data_hold_next;
  logic              expired;
  logic [3:0]        bit_inc;
  logic              done, rxv;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= 4'd0;
      shift_reg  <= 8'd0;
      parity_acc <= 1'b1;
      wait_timer <= '0;
      clock_hold <= 1'b0;
      data_hold  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      parity_acc <= parity_acc_next;
      wait_timer <= wait_timer_next;
      clock_hold <= clock_hold_next;
      data_hold  <= data_hold_next;
    end
  end

  // A wait of zero or one ends now; otherwise count down.
  assign expired = (wait_timer <= TICK_W'(1));
  assign bit_inc = bit_count + 4'd1;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    parity_acc_next = parity_acc;
    wait_timer_next = wait_timer;
    clock_hold_next = clock_hold;
    data_hold_next  = data_hold;
    done            = 1'b0;
    rxv             = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (item.operation == OP_WRITE) begin
          shift_reg_next  = item.tx_byte;
          parity_acc_next = 1'b1;
          bit_count_next  = 4'd0;
          clock_hold_next = 1'b0;
          data_hold_next  = 1'b0;
          wait_timer_next = cfg_q.inhibit_ticks;
          phase_next      = PH_W_REL;
        end else if (item.operation == OP_READ) begin
          shift_reg_next  = 8'd0;
          bit_count_next  = 4'd0;
          clock_hold_next = 1'b0;
          data_hold_next  = 1'b0;
          wait_timer_next = cfg_q.rx_release_ticks;
          phase_next      = PH_R_REL;
        end
      end
      PH_W_REL: begin
        if (expired) begin
          clock_hold_next = 1'b1;
          wait_timer_next = cfg_q.inhibit_ticks;
          phase_next      = PH_W_INH;
        end else begin
          wait_timer_next = wait_timer - TICK_W'(1);
        end
      end
      PH_W_INH: begin
        if (expired) begin
          data_hold_next  = 1'b1;
          wait_timer_next = cfg_q.request_setup_ticks;
          phase_next      = PH_W_REQ;
        end else begin
          wait_timer_next = wait_timer - TICK_W'(1);
        end
      end
      PH_W_REQ: begin
        if (expired) begin
          clock_hold_next = 1'b0;
          phase_next      = PH_W_DEV;
        end else begin
          wait_timer_next = wait_timer - TICK_W'(1);
        end
      end
      PH_W_DEV: begin
        if (!item.clock_level) begin
          data_hold_next = ~shift_reg[0];
          phase_next     = PH_W_BIT_HI;
        end
      end
      PH_W_BIT_HI: begin
        if (item.clock_level) phase_next = PH_W_BIT_LO;
      end
      PH_W_BIT_LO: begin
        if (!item.clock_level) begin
          parity_acc_next = parity_acc ^ shift_reg[0];
          shift_reg_next  = {1'b0, shift_reg[7:1]};
          bit_count_next  = bit_inc;
          if (bit_inc >= 4'd8) begin
            data_hold_next = ~(parity_acc ^ shift_reg[0]);
            phase_next     = PH_W_PAR_HI;
          end else begin
            data_hold_next = ~shift_reg[1];
            phase_next     = PH_W_BIT_HI;
          end
        end
      end
      PH_W_PAR_HI: begin
        if (item.clock_level) phase_next = PH_W_PAR_LO;
      end
      PH_W_PAR_LO: begin
        if (!item.clock_level) begin
          data_hold_next  = 1'b0;
          wait_timer_next = cfg_q.stop_hold_ticks;
          phase_next      = PH_W_STOP;
        end
      end
      PH_W_STOP: begin
        if (expired) phase_next = PH_W_ACK;
        else wait_timer_next = wait_timer - TICK_W'(1);
      end
      PH_W_ACK: begin
        if (!item.clock_level) phase_next = PH_W_END;
      end
      PH_W_END: begin
        if (item.clock_level && item.data_level) begin
          clock_hold_next = 1'b1;
          done            = 1'b1;
          phase_next      = PH_IDLE;
        end
      end
      PH_R_REL: begin
        if (expired) phase_next = PH_R_WAIT_LO;
        else wait_timer_next = wait_timer - TICK_W'(1);
      end
      PH_R_WAIT_LO: begin
        if (!item.clock_level) begin
          wait_timer_next = READ_GAP_TICKS;
          phase_next      = PH_R_GAP;
        end
      end
      PH_R_GAP: begin
        if (expired) phase_next = PH_R_START_HI;
        else wait_timer_next = wait_timer - TICK_W'(1);
      end
      PH_R_START_HI: begin
        if (item.clock_level) phase_next = PH_R_BIT_LO;
      end
      PH_R_BIT_LO: begin
        if (!item.clock_level) begin
          if (item.data_level) shift_reg_next[bit_count[2:0]] = 1'b1;
          phase_next = PH_R_BIT_HI;
        end
      end
      PH_R_BIT_HI: begin
        if (item.clock_level) begin
          bit_count_next = bit_inc;
          phase_next     = (bit_inc >= 4'd8) ? PH_R_PAR_LO : PH_R_BIT_LO;
        end
      end
      PH_R_PAR_LO: begin
        if (!item.clock_level) phase_next = PH_R_PAR_HI;
      end
      PH_R_PAR_HI: begin
        if (item.clock_level) phase_next = PH_R_STP_LO;
      end
      PH_R_STP_LO: begin
        if (!item.clock_level) phase_next = PH_R_STP_HI;
      end
      PH_R_STP_HI: begin
        if (item.clock_level) begin
          clock_hold_next = 1'b1;
          done            = 1'b1;
          rxv             = 1'b1;
          phase_next      = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res.clock_drive_low = clock_hold_next;
    res.data_drive_low  = data_hold_next;
    res.busy_res        = (phase_next != PH_IDLE);
    res.done_res        = done;
    res.rx_valid        = rxv;
    res.rx_byte         = rxv ? shift_reg : 8'd0;
  end

endmodule

### hdl/ps2_host_byte_transfer.sv
// PS/2 host byte transfer block: input register, phase machine and result register.
//
// Each word on req is one timebase tick carrying the sampled clock and data
// line levels; its operation field may start a byte write or a byte read when
// the block is idle. For every accepted tick exactly one word comes out on
// rsp with the line drives, busy, done and, at the end of a read, the byte.
// A word accepted on req first loads the input register; when it advances, the
// phase machine updates and the result register loads in the same cycle.
// Throughput is one tick per cycle while rsp is not stalled, set by the
// combinational next-state logic between the two registers.
// When rsp is stalled the result register holds its word and the input
// register still takes one more tick; req.ready drops only when both are full.
// The cfg channel is always ready and writes one wait-length register per word.
// Reset empties both registers and returns the machine to idle with both lines
// released and the wait lengths at their defaults.
module ps2_host_byte_transfer (
  input  logic     clk,
  input  logic     rst,
  ps2h_req_if.sink  req,
  ps2h_rsp_if.source rsp,
  ps2h_cfg_if.sink  cfg
);
  import ps2h_pkg::*;

  cfg_t    cfg_q;
  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t step_res;
  logic    out_valid;
  result_t out_res;

  ps2h_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.operation   <= req.operation;
      s1_item.tx_byte     <= req.tx_byte;
      s1_item.clock_level <= req.clock_level;
      s1_item.data_level  <= req.data_level;
    end
  end

  ps2h_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .cfg_q (cfg_q),
    .item  (s1_item),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= step_res;
  end

  assign rsp.valid           = out_valid;
  assign rsp.clock_drive_low = out_res.clock_drive_low;
  assign rsp.data_drive_low  = out_res.data_drive_low;
  assign rsp.busy_res        = out_res.busy_res;
  assign rsp.done_res        = out_res.done_res;
  assign rsp.rx_valid        = out_res.rx_valid;
  assign rsp.rx_byte         = out_res.rx_byte;

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |-> !out_res.busy_res)
    else $error("done word reports busy");

  a_rx_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.rx_valid |-> out_res.done_res)
    else $error("received byte without done");

  a_rx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.rx_valid |-> out_res.rx_byte == 8'd0)
    else $error("byte field set outside a read end");

  a_tick_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("pending tick dropped while result stalled");
`endif

endmodule
